>>> rtl/core/olvs_pkg.sv
// ----------------------------------------------------------------------------
// olvs_pkg
// Shared types, field widths and codes for the ordered value list store.
// ----------------------------------------------------------------------------
package olvs_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned STS_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 7;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PREPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SORT    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd5;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [ACT_W-1:0] action;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] element;
    logic [POS_W-1:0] position;
    logic [STS_W-1:0] status;
  } res_t;

endpackage

>>> rtl/core/olvs_mem.sv
// ----------------------------------------------------------------------------
// olvs_mem
// Single-clock RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module olvs_mem #(
  parameter int unsigned DEPTH = olvs_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = olvs_pkg::VAL_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/olvs_seq.sv
// ----------------------------------------------------------------------------
// olvs_seq
// Command sequencer: decodes a transaction, walks the entry RAM one read per
// cycle (scan, gap close, gap open, bubble pass, indexed read) and builds the result.
// ----------------------------------------------------------------------------
module olvs_seq #(
  parameter int unsigned CAPACITY = olvs_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  olvs_pkg::cmd_t                   cmd,
  output logic                             res_valid,
  input  logic                             res_ready,
  output olvs_pkg::res_t                   res,
  output logic                             mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
  input  logic [olvs_pkg::VAL_W-1:0]       mem_rd_data,
  output logic                             mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
  output logic [olvs_pkg::VAL_W-1:0]       mem_wr_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + olvs_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CLOSE,
    ST_OPEN,
    ST_SORT,
    ST_GET,
    ST_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  olvs_pkg::cmd_t                 cmd_r;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic [AW-1:0]                  rptr_r, rptr_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;
  logic [AW-1:0]                  paddr_r, paddr_nxt;
  logic [olvs_pkg::VAL_W-1:0]     carry_r, carry_nxt;
  logic                           swapped_r, swapped_nxt;
  logic                           first_r, first_nxt;
  logic [AW-1:0]                  where_r, where_nxt;
  logic [olvs_pkg::STS_W-1:0]     status_r, status_nxt;
  logic [olvs_pkg::VAL_W-1:0]     element_r, element_nxt;

  logic                           walking;
  logic                           issue;
  logic                           walk_end;
  logic                           is_full;
  logic [XW-1:0]                  idx_ext;
  logic [XW-1:0]                  fill_ext;

  assign walking  = (state_r == ST_SCAN) || (state_r == ST_CLOSE) ||
                    (state_r == ST_OPEN) || (state_r == ST_SORT) || (state_r == ST_GET);
  assign issue    = walking && (cnt_r != '0);
  assign walk_end = (cnt_r == '0) && !pend_r;
  assign is_full  = (fill_r == CW'(CAPACITY));
  assign idx_ext  = XW'(cmd_r.index);
  assign fill_ext = XW'(fill_r);

  assign cmd_ready   = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign mem_rd_en   = issue;
  assign mem_rd_addr = rptr_r;

  assign res.status   = status_r;
  assign res.position = olvs_pkg::POS_W'(where_r);
  assign res.element  = element_r;
  assign res.count    = olvs_pkg::CNT_W'(fill_r);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    rptr_nxt    = (state_r == ST_OPEN) ? rptr_r - 1'b1 : rptr_r + 1'b1;
    cnt_nxt     = issue ? cnt_r - 1'b1 : cnt_r;
    pend_nxt    = issue;
    paddr_nxt   = rptr_r;
    carry_nxt   = carry_r;
    swapped_nxt = swapped_r;
    first_nxt   = first_r;
    where_nxt   = where_r;
    status_nxt  = status_r;
    element_nxt = element_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = carry_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        status_nxt  = olvs_pkg::STS_OK;
        where_nxt   = '0;
        element_nxt = '0;
        rptr_nxt    = '0;
        cnt_nxt     = fill_r;
        first_nxt   = 1'b1;
        swapped_nxt = 1'b0;
        state_nxt   = ST_DONE;
        unique case (cmd_r.action)
          olvs_pkg::ACT_APPEND: begin
            if (is_full) begin
              status_nxt = olvs_pkg::STS_FULL;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(fill_r);
              mem_wr_data = cmd_r.value;
              fill_nxt    = fill_r + 1'b1;
            end
          end
          olvs_pkg::ACT_PREPEND: begin
            if (is_full) begin
              status_nxt = olvs_pkg::STS_FULL;
            end else begin
              rptr_nxt  = AW'(fill_r - 1'b1);
              state_nxt = ST_OPEN;
            end
          end
          olvs_pkg::ACT_SEARCH, olvs_pkg::ACT_DELETE: begin
            state_nxt = ST_SCAN;
          end
          olvs_pkg::ACT_SORT: begin
            if (fill_r > CW'(1)) begin
              state_nxt = ST_SORT;
            end
          end
          olvs_pkg::ACT_READ: begin
            if (idx_ext < fill_ext) begin
              rptr_nxt  = AW'(cmd_r.index);
              cnt_nxt   = CW'(1);
              state_nxt = ST_GET;
            end else begin
              status_nxt = olvs_pkg::STS_BAD_INDEX;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        if (pend_r && (mem_rd_data == cmd_r.value)) begin
          where_nxt = paddr_r;
          pend_nxt  = 1'b0;
          if (cmd_r.action == olvs_pkg::ACT_DELETE) begin
            rptr_nxt  = paddr_r + 1'b1;
            cnt_nxt   = fill_r - 1'b1 - CW'(paddr_r);
            state_nxt = ST_CLOSE;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (walk_end) begin
          status_nxt = olvs_pkg::STS_NOT_FOUND;
          state_nxt  = ST_DONE;
        end
      end

      ST_CLOSE: begin
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = paddr_r - 1'b1;
          mem_wr_data = mem_rd_data;
        end
        if (walk_end) begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_OPEN: begin
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = paddr_r + 1'b1;
          mem_wr_data = mem_rd_data;
        end
        if (walk_end) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = '0;
          mem_wr_data = cmd_r.value;
          fill_nxt    = fill_r + 1'b1;
          state_nxt   = ST_DONE;
        end
      end

      ST_SORT: begin
        // running maximum rides in carry_r through one bubble pass
        if (pend_r) begin
          if (first_r) begin
            carry_nxt = mem_rd_data;
            first_nxt = 1'b0;
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = paddr_r - 1'b1;
            if ($signed(carry_r) > $signed(mem_rd_data)) begin
              mem_wr_data = mem_rd_data;
              swapped_nxt = 1'b1;
            end else begin
              mem_wr_data = carry_r;
              carry_nxt   = mem_rd_data;
            end
          end
        end
        if (walk_end) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(fill_r - 1'b1);
          mem_wr_data = carry_r;
          if (swapped_r) begin
            rptr_nxt    = '0;
            cnt_nxt     = fill_r;
            first_nxt   = 1'b1;
            swapped_nxt = 1'b0;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_GET: begin
        if (pend_r) begin
          element_nxt = mem_rd_data;
          state_nxt   = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    rptr_r    <= rptr_nxt;
    paddr_r   <= paddr_nxt;
    carry_r   <= carry_nxt;
    swapped_r <= swapped_nxt;
    first_r   <= first_nxt;
    where_r   <= where_nxt;
    status_r  <= status_nxt;
    element_r <= element_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill above capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |->
      (fill_r == $past(fill_r) + 1'b1) || (fill_r == $past(fill_r) - 1'b1))
    else $error("fill moved by more than one");

  a_fill_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |-> state_r == ST_DONE)
    else $error("fill changed outside command completion");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("read and write to same entry in one cycle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> CW'(mem_wr_addr) <= fill_r)
    else $error("write beyond list tail");

endmodule

>>> rtl/core/ordered_value_list_store_core.sv
// ----------------------------------------------------------------------------
// ordered_value_list_store_core
// Bounded list of signed 32-bit values with append, prepend, search, delete,
// ascending sort and indexed read; one result transaction per command.
// ----------------------------------------------------------------------------
// One command is in work at a time; the next input transaction is taken
// while the previous result still sits in the output register. Search
// walks the stored values in order, delete also closes the gap behind the
// match, prepend shifts every entry up one place and sort repeats bubble
// passes until one pass makes no swap. The walks step through the entry RAM
// one entry per cycle over its single read port. No clearing pass after reset.
module ordered_value_list_store_core #(
  parameter int unsigned CAPACITY = olvs_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] action, [34:3] value, [40:35] index, [47:41] zero
  input  logic [olvs_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [7:2] position, [39:8] element, [46:40] count, [47] zero
  output logic [olvs_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned AW      = $clog2(CAPACITY);
  localparam int unsigned CMD_W   = $bits(olvs_pkg::cmd_t);
  localparam int unsigned RES_W   = $bits(olvs_pkg::res_t);

  olvs_pkg::cmd_t              cmd;
  olvs_pkg::res_t              res;
  logic                        res_valid;
  logic                        res_ready;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [olvs_pkg::VAL_W-1:0]  mem_rd_data;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [olvs_pkg::VAL_W-1:0]  mem_wr_data;

  logic                        out_tvalid_r;
  olvs_pkg::res_t              out_res_r;

  assign cmd = olvs_pkg::cmd_t'(in_tdata[CMD_W-1:0]);

  olvs_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  olvs_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (olvs_pkg::VAL_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = olvs_pkg::OUT_DATA_W'(RES_W'(out_res_r));

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered value list store. Commands go in on the
// input stream and each one is applied to a shadow list in the scoreboard.
// Every result transaction is compared field by field with the oldest
// predicted result. Directed corner cases run first, then random traffic
// that alternates between growing the list to full and draining it, under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------

class list_scoreboard;
  localparam int CAP = olvs_pkg::CAPACITY_DEF;

  logic [olvs_pkg::VAL_W-1:0] vals[CAP];
  int                         fill;
  olvs_pkg::res_t             results_due[$];
  int unsigned                errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function void note_cmd(olvs_pkg::cmd_t c);
    olvs_pkg::res_t             r;
    int                         where;
    bit                         swapped;
    logic [olvs_pkg::VAL_W-1:0] t;
    r     = '0;
    where = -1;
    case (c.action)
      olvs_pkg::ACT_APPEND: begin
        if (fill >= CAP) begin
          r.status = olvs_pkg::STS_FULL;
        end else begin
          vals[fill] = c.value;
          fill++;
        end
      end
      olvs_pkg::ACT_PREPEND: begin
        if (fill >= CAP) begin
          r.status = olvs_pkg::STS_FULL;
        end else begin
          for (int i = fill; i > 0; i--) vals[i] = vals[i-1];
          vals[0] = c.value;
          fill++;
        end
      end
      olvs_pkg::ACT_SEARCH, olvs_pkg::ACT_DELETE: begin
        for (int i = 0; i < fill; i++) begin
          if (where < 0 && vals[i] == c.value) where = i;
        end
        if (where < 0) begin
          r.status = olvs_pkg::STS_NOT_FOUND;
        end else begin
          r.position = olvs_pkg::POS_W'(where);
          if (c.action == olvs_pkg::ACT_DELETE) begin
            for (int i = where; i + 1 < fill; i++) vals[i] = vals[i+1];
            fill--;
          end
        end
      end
      olvs_pkg::ACT_SORT: begin
        swapped = 1'b1;
        while (swapped) begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < fill; i++) begin
            if ($signed(vals[i]) > $signed(vals[i+1])) begin
              t         = vals[i];
              vals[i]   = vals[i+1];
              vals[i+1] = t;
              swapped   = 1'b1;
            end
          end
        end
      end
      olvs_pkg::ACT_READ: begin
        if (int'(c.index) < fill) r.element = vals[c.index];
        else r.status = olvs_pkg::STS_BAD_INDEX;
      end
      default: ;
    endcase
    r.count = olvs_pkg::CNT_W'(fill);
    results_due.push_back(r);
  endfunction

  function void check_result(olvs_pkg::res_t got);
    olvs_pkg::res_t want;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result with nothing pending: sts=%0d pos=%0d elem=%h cnt=%0d",
                 got.status, got.position, got.element, got.count);
      return;
    end
    want = results_due.pop_front();
    if (got.status != want.status || got.position != want.position ||
        got.element != want.element || got.count != want.count) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: exp sts=%0d pos=%0d elem=%h cnt=%0d, got sts=%0d pos=%0d elem=%h cnt=%0d",
                 want.status, want.position, want.element, want.count,
                 got.status, got.position, got.element, got.count);
    end
  endfunction
endclass

module tb_top;
  import olvs_pkg::*;

  localparam int          CAP      = CAPACITY_DEF;
  localparam int unsigned LIMIT    = 4_000_000;
  localparam int          HOLD_LEN = 400;
  localparam int          PHASE_N  = 100;

  localparam logic [ACT_W-1:0] ACT_NOP_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOP_B = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic        long_hold = 1'b0;
  logic        hold_go   = 1'b0;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycles    = 0;

  list_scoreboard sb = new();

  ordered_value_list_store_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= long_hold ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // long receiver hold-off; the input side keeps offering transactions
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(res_t'(out_tdata[$bits(res_t)-1:0]));
  end

  function automatic cmd_t mk_cmd(logic [ACT_W-1:0] a, logic [VAL_W-1:0] v,
                                  logic [IDX_W-1:0] idx);
    cmd_t c;
    c.action = a;
    c.value  = v;
    c.index  = idx;
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(int hit_pct);
    int r;
    if (sb.fill > 0 && $urandom_range(0, 99) < hit_pct)
      return sb.vals[$urandom_range(0, sb.fill - 1)];
    r = $urandom_range(0, 9);
    if (r < 4) return VAL_W'($urandom_range(0, 15)) - 32'd8;
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd(bit grow);
    cmd_t c;
    int   r;
    r       = $urandom_range(0, 99);
    c.index = IDX_W'($urandom);
    c.value = $urandom;
    if (grow) begin
      if (r < 35)      c.action = ACT_APPEND;
      else if (r < 60) c.action = ACT_PREPEND;
      else if (r < 70) c.action = ACT_SEARCH;
      else if (r < 78) c.action = ACT_DELETE;
      else if (r < 95) c.action = ACT_READ;
      else if (r < 97) c.action = ACT_SORT;
      else             c.action = $urandom_range(0, 1) ? ACT_NOP_A : ACT_NOP_B;
    end else begin
      if (r < 5)       c.action = ACT_APPEND;
      else if (r < 10) c.action = ACT_PREPEND;
      else if (r < 20) c.action = ACT_SEARCH;
      else if (r < 75) c.action = ACT_DELETE;
      else if (r < 93) c.action = ACT_READ;
      else if (r < 95) c.action = ACT_SORT;
      else             c.action = $urandom_range(0, 1) ? ACT_NOP_A : ACT_NOP_B;
    end
    case (c.action)
      ACT_APPEND, ACT_PREPEND: c.value = pick_value(20);
      ACT_SEARCH, ACT_DELETE:  c.value = pick_value(85);
      ACT_READ: begin
        if (sb.fill > 0 && $urandom_range(0, 99) < 70)
          c.index = IDX_W'($urandom_range(0, sb.fill - 1));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send(cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(c);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_cmd(c);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.results_due.size() > 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, bit with_hold);
    cmd_t c;
    int   n;
    int   at_full;
    bit   grow;
    n         = 0;
    at_full   = 0;
    grow      = 1'b1;
    idle_pct  = idle;
    stall_pct <= stall;
    if (with_hold) hold_go <= 1'b1;
    while (n < PHASE_N) begin
      if (grow && sb.fill == CAP) begin
        at_full++;
        if (at_full > 6) begin
          grow    = 1'b0;
          at_full = 0;
        end
      end else if (!grow && sb.fill == 0) begin
        grow = 1'b1;
      end
      c = pick_cmd(grow);
      send(c);
      if (c.action != ACT_NOP_A && c.action != ACT_NOP_B) n++;
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, single element, duplicates, extremes, sort, bad index, unused action codes
    stall_pct <= 0;
    send(mk_cmd(ACT_READ,    32'd0,         6'd0));
    send(mk_cmd(ACT_SEARCH,  32'd5,         6'd0));
    send(mk_cmd(ACT_DELETE,  32'd5,         6'd0));
    send(mk_cmd(ACT_SORT,    32'd0,         6'd0));
    send(mk_cmd(ACT_PREPEND, 32'h7fff_ffff, 6'd0));
    send(mk_cmd(ACT_SORT,    32'd0,         6'd0));
    send(mk_cmd(ACT_READ,    32'd0,         6'd0));
    send(mk_cmd(ACT_APPEND,  32'h8000_0000, 6'd0));
    send(mk_cmd(ACT_APPEND,  32'hffff_ffff, 6'd0));
    send(mk_cmd(ACT_PREPEND, 32'd0,         6'd0));
    send(mk_cmd(ACT_APPEND,  32'd5,         6'd0));
    send(mk_cmd(ACT_PREPEND, 32'd5,         6'd0));
    send(mk_cmd(ACT_SEARCH,  32'd5,         6'd0));
    send(mk_cmd(ACT_SEARCH,  32'h8000_0000, 6'd0));
    send(mk_cmd(ACT_SEARCH,  32'd1234,      6'd0));
    send(mk_cmd(ACT_DELETE,  32'd0,         6'd0));
    send(mk_cmd(ACT_READ,    32'd0,         6'd63));
    send(mk_cmd(ACT_READ,    32'd0,         6'd4));
    send(mk_cmd(ACT_SORT,    32'd0,         6'd0));
    send(mk_cmd(ACT_READ,    32'd0,         6'd0));
    send(mk_cmd(ACT_READ,    32'd0,         6'd4));
    send(mk_cmd(ACT_NOP_A,   $urandom,      6'd63));
    send(mk_cmd(ACT_NOP_B,   $urandom,      6'd42));
    send(mk_cmd(ACT_DELETE,  32'h7fff_ffff, 6'd0));
    send(mk_cmd(ACT_APPEND,  32'h5555_aaaa, 6'd63));
    drain();

    run_phase(0,  0,  1'b1);
    run_phase(77, 0,  1'b0);
    run_phase(0,  77, 1'b0);
    run_phase(11, 11, 1'b0);

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
